FILE: rtl/lpn2ab_pkg.sv
// shared types and constants of the length-prefixed nal to annex-b converter
package lpn2ab_pkg;

  // default sizes of the parameter-set store and the subsample queue
  localparam int PARAM_SET_DEPTH_DEF = 48;
  localparam int MAX_SUBSAMPLES_DEF  = 16;

  // fixed field widths; they cover a parameter-set depth of up to 63
  localparam int PS_LEN_W  = 6;
  localparam int PS_ADDR_W = 6;

  // input opcodes
  localparam logic [1:0] OP_PARAM  = 2'd0;
  localparam logic [1:0] OP_DESC   = 2'd1;
  localparam logic [1:0] OP_SAMPLE = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_BYTE   = 2'd0;
  localparam logic [1:0] KIND_CLEAR  = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // end status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OVERRUN = 2'd1;
  localparam logic [1:0] ST_INCOMP  = 2'd2;
  localparam logic [1:0] ST_UNSUP   = 2'd3;

  // configuration register indexes
  localparam logic CFG_NLS = 1'b0;
  localparam logic CFG_ENC = 1'b1;

  // one classified sample byte: which beats the back end must produce
  typedef struct packed {
    logic                inj;
    logic [PS_LEN_W-1:0] inj_len;
    logic                start;
    logic                byte_en;
    logic [7:0]          byte_val;
    logic                clr_en;
    logic [15:0]         clr;
    logic                st_en;
    logic [1:0]          st;
  } cmd_t;

  // write port of the parameter-set store
  typedef struct packed {
    logic                 en;
    logic [PS_ADDR_W-1:0] addr;
    logic [7:0]           data;
  } ps_wr_t;

endpackage

FILE: rtl/lpn2ab_front.sv
// front end: accepts items, tracks units and subsamples, issues commands
module lpn2ab_front #(
  parameter int PARAM_SET_DEPTH = lpn2ab_pkg::PARAM_SET_DEPTH_DEF,
  parameter int MAX_SUBSAMPLES  = lpn2ab_pkg::MAX_SUBSAMPLES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [2:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          opcode,
  input  logic [7:0]          data_byte,
  input  logic [15:0]         clear_bytes,
  input  logic [31:0]         encrypted_bytes,
  input  logic                last,
  output lpn2ab_pkg::cmd_t    cmd,
  output logic                cmd_push,
  input  logic                cmd_full,
  input  logic                back_idle,
  output lpn2ab_pkg::ps_wr_t  ps_wr
);

  localparam int PSW = $clog2(PARAM_SET_DEPTH + 1);
  localparam int QW  = $clog2(MAX_SUBSAMPLES + 1);
  localparam int QAW = (MAX_SUBSAMPLES > 1) ? $clog2(MAX_SUBSAMPLES) : 1;

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_PREFIX  = 3'd1;
  localparam logic [2:0] PH_HEADER  = 3'd2;
  localparam logic [2:0] PH_BODY    = 3'd3;
  localparam logic [2:0] PH_PASS    = 3'd4;
  localparam logic [2:0] PH_DISCARD = 3'd5;

  logic [2:0]     reg_nls;
  logic           reg_enc;
  logic [2:0]     phase, phase_next;
  logic [31:0]    lacc, lacc_next;
  logic [2:0]     pbc, pbc_next;
  logic [31:0]    prem, prem_next;
  logic [32:0]    usum, usum_next;
  logic [15:0]    adj, adj_next;
  logic [PSW-1:0] psl, psl_next;
  logic [QW-1:0]  head, head_next;
  logic [QW-1:0]  tail;
  logic [2:0]     cur_nls, cur_nls_next;
  logic           cur_enc, cur_enc_next;
  logic [1:0]     end_code, end_code_next;
  logic [31:0]    sbytes, sbytes_next;
  logic           reload, reload_next;
  logic [15:0]    clearq  [MAX_SUBSAMPLES];
  logic [31:0]    cipherq [MAX_SUBSAMPLES];

  lpn2ab_pkg::cmd_t c;
  logic        hv;
  logic [15:0] hc;
  logic [32:0] lim_q;
  logic        acc;
  logic        take_sample;

  function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] v);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, v};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  // head of the subsample queue
  assign hv    = (head < tail);
  assign hc    = hv ? clearq[head[QAW-1:0]] : 16'd0;
  assign lim_q = hv ? ({17'd0, clearq[head[QAW-1:0]]} + {1'b0, cipherq[head[QAW-1:0]]})
                    : 33'd0;

  // handshakes
  assign cfg_ready = 1'b1;
  always_comb begin
    priority if (reload)                 in_ready = 1'b0;
    else if (opcode == lpn2ab_pkg::OP_SAMPLE) in_ready = !cmd_full;
    else if (opcode == lpn2ab_pkg::OP_PARAM)  in_ready = back_idle;
    else                                 in_ready = 1'b1;
  end
  assign acc         = in_valid && in_ready;
  assign take_sample = acc && (opcode == lpn2ab_pkg::OP_SAMPLE);

  // parameter-set store write
  always_comb begin
    ps_wr.en   = acc && (opcode == lpn2ab_pkg::OP_PARAM) && (psl < PSW'(PARAM_SET_DEPTH));
    ps_wr.addr = lpn2ab_pkg::PS_ADDR_W'(psl);
    ps_wr.data = data_byte;
  end

  // per-byte classification
  always_comb begin
    logic [31:0] lacc_eff;
    logic [33:0] tot;
    logic [33:0] lim;
    logic        do_inj;
    logic        inj_en;
    logic        unit_done;
    phase_next    = phase;
    lacc_next     = lacc;
    pbc_next      = pbc;
    prem_next     = prem;
    usum_next     = usum;
    adj_next      = adj;
    psl_next      = psl;
    head_next     = head;
    cur_nls_next  = cur_nls;
    cur_enc_next  = cur_enc;
    end_code_next = end_code;
    sbytes_next   = sbytes;
    reload_next   = 1'b0;
    c             = '0;
    do_inj        = 1'b0;
    inj_en        = 1'b0;
    unit_done     = 1'b0;

    // sample start
    if (phase == PH_IDLE) begin
      sbytes_next   = 32'd0;
      cur_nls_next  = reg_nls;
      cur_enc_next  = reg_enc;
      end_code_next = lpn2ab_pkg::ST_OK;
      usum_next     = 33'd0;
      lacc_next     = 32'd0;
      pbc_next      = 3'd0;
      prem_next     = 32'd0;
      if (reg_nls > 3'd4) begin
        end_code_next = lpn2ab_pkg::ST_UNSUP;
        phase_next    = PH_DISCARD;
      end else if (reg_nls == 3'd0 || (reg_enc && (!hv || hc == 16'd0))) begin
        psl_next   = '0;
        phase_next = PH_PASS;
      end else begin
        if (reg_enc) adj_next = hc;
        phase_next = PH_PREFIX;
      end
    end
    if (sbytes_next != 32'hFFFF_FFFF) sbytes_next = sbytes_next + 32'd1;

    // one adder serves unit end and the incomplete-sample check
    lacc_eff = (phase_next == PH_PREFIX) ? {lacc_next[23:0], data_byte} : lacc_next;
    tot = (cur_enc_next ? {1'b0, usum_next} : 34'd0) + {31'd0, cur_nls_next}
        + {2'd0, lacc_eff};
    lim = cur_enc_next ? {1'b0, lim_q} : {2'd0, sbytes_next};

    unique case (phase_next)
      PH_PASS: begin
        c.byte_en  = 1'b1;
        c.byte_val = data_byte;
      end
      PH_PREFIX: begin
        lacc_next = lacc_eff;
        pbc_next  = pbc_next + 3'd1;
        if (pbc_next >= cur_nls_next) begin
          if (cur_enc_next) adj_next = sat_add(adj_next, 16'(3'd4 - cur_nls_next));
          prem_next = lacc_next;
          if (lacc_next == 32'd0) begin
            inj_en    = 1'b1;
            do_inj    = 1'b1;
            unit_done = 1'b1;
          end else begin
            phase_next = PH_HEADER;
          end
        end
      end
      PH_HEADER, PH_BODY: begin
        if (phase_next == PH_HEADER) begin
          inj_en     = 1'b1;
          do_inj     = ((data_byte & 8'h1F) != 8'd9);
          phase_next = PH_BODY;
        end
        c.byte_en  = 1'b1;
        c.byte_val = data_byte;
        prem_next  = prem_next - 32'd1;
        if (prem_next == 32'd0) unit_done = 1'b1;
      end
      default: begin
      end
    endcase

    // parameter-set injection and start code
    if (inj_en) begin
      c.start = 1'b1;
      if (do_inj && psl_next != '0) begin
        c.inj     = 1'b1;
        c.inj_len = lpn2ab_pkg::PS_LEN_W'(psl_next);
        if (cur_enc_next) adj_next = sat_add(adj_next, 16'(psl_next));
        psl_next = '0;
      end
    end

    // unit end against the current subsample
    if (unit_done) begin
      phase_next = PH_PREFIX;
      pbc_next   = 3'd0;
      if (cur_enc_next) begin
        if (tot > lim) begin
          end_code_next = lpn2ab_pkg::ST_OVERRUN;
          phase_next    = PH_DISCARD;
        end else if (tot == lim) begin
          c.clr_en    = 1'b1;
          c.clr       = adj_next;
          head_next   = head + QW'(1);
          reload_next = 1'b1;
          usum_next   = 33'd0;
        end else begin
          usum_next = tot[32:0];
        end
      end
      lacc_next = 32'd0;
    end

    // end of sample
    if (last) begin
      c.st_en = 1'b1;
      priority if (phase_next == PH_DISCARD) c.st = end_code_next;
      else if (phase_next == PH_PASS)        c.st = lpn2ab_pkg::ST_OK;
      else if (phase_next == PH_PREFIX) begin
        if (pbc_next != 3'd0)                         c.st = lpn2ab_pkg::ST_INCOMP;
        else if (cur_enc_next && head_next < tail)    c.st = lpn2ab_pkg::ST_INCOMP;
        else                                          c.st = lpn2ab_pkg::ST_OK;
      end else begin
        c.st = (tot > lim) ? lpn2ab_pkg::ST_OVERRUN : lpn2ab_pkg::ST_INCOMP;
      end
      phase_next    = PH_IDLE;
      head_next     = '0;
      lacc_next     = 32'd0;
      pbc_next      = 3'd0;
      prem_next     = 32'd0;
      usum_next     = 33'd0;
      adj_next      = 16'd0;
      end_code_next = lpn2ab_pkg::ST_OK;
      sbytes_next   = 32'd0;
      reload_next   = 1'b0;
    end
  end

  assign cmd      = c;
  assign cmd_push = take_sample && (c.inj || c.start || c.byte_en || c.clr_en || c.st_en);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      reg_nls  <= 3'd4;
      reg_enc  <= 1'b0;
      phase    <= PH_IDLE;
      lacc     <= 32'd0;
      pbc      <= 3'd0;
      prem     <= 32'd0;
      usum     <= 33'd0;
      adj      <= 16'd0;
      psl      <= '0;
      head     <= '0;
      tail     <= '0;
      cur_nls  <= 3'd0;
      cur_enc  <= 1'b0;
      end_code <= lpn2ab_pkg::ST_OK;
      sbytes   <= 32'd0;
      reload   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == lpn2ab_pkg::CFG_NLS) reg_nls <= cfg_data;
        else                                  reg_enc <= cfg_data[0];
      end
      if (reload) begin
        adj    <= hc;
        reload <= 1'b0;
      end
      if (ps_wr.en) psl <= psl + PSW'(1);
      if (acc && opcode == lpn2ab_pkg::OP_DESC && tail < QW'(MAX_SUBSAMPLES)) begin
        tail <= tail + QW'(1);
      end
      if (take_sample) begin
        phase    <= phase_next;
        lacc     <= lacc_next;
        pbc      <= pbc_next;
        prem     <= prem_next;
        usum     <= usum_next;
        adj      <= adj_next;
        psl      <= psl_next;
        head     <= head_next;
        cur_nls  <= cur_nls_next;
        cur_enc  <= cur_enc_next;
        end_code <= end_code_next;
        sbytes   <= sbytes_next;
        reload   <= reload_next;
        if (last) tail <= '0;
      end
    end
  end

  // subsample descriptor storage
  always_ff @(posedge clk) begin
    if (acc && opcode == lpn2ab_pkg::OP_DESC && tail < QW'(MAX_SUBSAMPLES)) begin
      clearq[tail[QAW-1:0]]  <= clear_bytes;
      cipherq[tail[QAW-1:0]] <= encrypted_bytes;
    end
  end

endmodule

FILE: rtl/lpn2ab_fifo.sv
// two-entry command queue between front and back end
module lpn2ab_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lpn2ab_pkg::cmd_t wdata,
  output logic             full,
  input  logic             pop,
  output logic             rvalid,
  output lpn2ab_pkg::cmd_t rdata
);

  lpn2ab_pkg::cmd_t mem [2];
  logic       wptr, rptr;
  logic [1:0] count;

  assign full   = (count == 2'd2);
  assign rvalid = (count != 2'd0);
  assign rdata  = mem[rptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

endmodule

FILE: rtl/lpn2ab_back.sv
// back end: expands commands into result beats, holds the parameter-set store
module lpn2ab_back #(
  parameter int PARAM_SET_DEPTH = lpn2ab_pkg::PARAM_SET_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  lpn2ab_pkg::ps_wr_t ps_wr,
  input  logic               cmd_valid,
  input  lpn2ab_pkg::cmd_t   cmd,
  output logic               cmd_pop,
  output logic               busy,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         kind,
  output logic [7:0]         out_byte,
  output logic [15:0]        clear_count,
  output logic [1:0]         status,
  output logic               last_res
);

  localparam int PSW  = $clog2(PARAM_SET_DEPTH + 1);
  localparam int PSAW = (PARAM_SET_DEPTH > 1) ? $clog2(PARAM_SET_DEPTH) : 1;

  localparam logic [2:0] S_INJ   = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_BYTE  = 3'd2;
  localparam logic [2:0] S_CLR   = 3'd3;
  localparam logic [2:0] S_ST    = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [7:0]       mem [PARAM_SET_DEPTH];
  logic [7:0]       rdata;
  logic             rd_ok;
  logic [PSW-1:0]   idx;
  lpn2ab_pkg::cmd_t cur;
  logic             cur_valid;
  logic [2:0]       step, step_next;
  logic [1:0]       sc;
  logic             slot_free, emit;

  function automatic logic [2:0] first_from(input lpn2ab_pkg::cmd_t c, input logic [2:0] s);
    priority if (s <= S_INJ && c.inj)       return S_INJ;
    else if (s <= S_START && c.start)       return S_START;
    else if (s <= S_BYTE && c.byte_en)      return S_BYTE;
    else if (s <= S_CLR && c.clr_en)        return S_CLR;
    else if (s <= S_ST && c.st_en)          return S_ST;
    else                                    return S_DONE;
  endfunction

  // parameter-set memory
  always_ff @(posedge clk) begin
    if (ps_wr.en) mem[ps_wr.addr[PSAW-1:0]] <= ps_wr.data;
    rdata <= mem[idx[PSAW-1:0]];
  end

  assign busy      = cur_valid;
  assign slot_free = !out_valid || out_ready;
  assign emit      = cur_valid && slot_free && (step != S_INJ || rd_ok);
  assign cmd_pop   = cmd_valid && (!cur_valid || (emit && step_next == S_DONE));

  // step after the current beat
  always_comb begin
    unique case (step)
      S_INJ:   step_next = (idx == PSW'(cur.inj_len) - PSW'(1)) ? first_from(cur, S_START)
                                                                : S_INJ;
      S_START: step_next = (sc == 2'd3) ? first_from(cur, S_BYTE) : S_START;
      S_BYTE:  step_next = first_from(cur, S_CLR);
      S_CLR:   step_next = first_from(cur, S_ST);
      default: step_next = S_DONE;
    endcase
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
      step      <= S_DONE;
      idx       <= '0;
      sc        <= 2'd0;
      rd_ok     <= 1'b0;
    end else begin
      rd_ok <= !(emit && step == S_INJ);
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (emit) begin
        out_valid   <= 1'b1;
        kind        <= lpn2ab_pkg::KIND_BYTE;
        out_byte    <= 8'd0;
        clear_count <= 16'd0;
        status      <= lpn2ab_pkg::ST_OK;
        last_res    <= 1'b0;
        unique case (step)
          S_INJ: begin
            out_byte <= rdata;
            idx      <= (step_next == S_INJ) ? idx + PSW'(1) : '0;
          end
          S_START: begin
            out_byte <= (sc == 2'd3) ? 8'd1 : 8'd0;
            sc       <= sc + 2'd1;
          end
          S_BYTE: out_byte <= cur.byte_val;
          S_CLR: begin
            kind        <= lpn2ab_pkg::KIND_CLEAR;
            clear_count <= cur.clr;
          end
          default: begin
            kind     <= lpn2ab_pkg::KIND_STATUS;
            status   <= cur.st;
            last_res <= 1'b1;
          end
        endcase
        step <= step_next;
      end
      if (cmd_pop) begin
        cur_valid <= 1'b1;
        cur       <= cmd;
        step      <= first_from(cmd, S_INJ);
      end else if (emit && step_next == S_DONE) begin
        cur_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/length_prefixed_nal_to_annexb.sv
// top level of the length-prefixed nal to annex-b converter
//
// in channel: one item per beat. opcode selects a parameter-set byte, a
// subsample descriptor or a sample byte; last marks a sample's final byte.
// cfg channel: cfg_index 0 writes the prefix length size, 1 encrypted_mode;
// always ready; write only between samples (the block does not enforce it).
// out channel: one result per beat (stream byte, adjusted clear count or end
// status with last_res set).
// throughput: one sample byte per cycle while out_ready stays high and the
// command queue is not full; a byte that opens a unit adds four start-code
// beats, and an injected parameter set waits for the registered store read
// of each stored byte before emitting it. after a subsample closes, the
// front end pauses to load the next clear count from the descriptor queue.
// a parameter-set byte waits until the back end drains all queued commands.
// path: with nothing queued ahead, a byte's result passes through its command
// queue entry and the back end's command register into the output register.
// reset: clears all control state, empties the queue and the parameter set
// length and restores a length size of 4 and encrypted_mode 0.
// stall: while out_ready is low the back end holds its beat, the two-entry
// command queue fills, and then in_ready drops for sample bytes.
module length_prefixed_nal_to_annexb #(
  parameter int PARAM_SET_DEPTH = lpn2ab_pkg::PARAM_SET_DEPTH_DEF,
  parameter int MAX_SUBSAMPLES  = lpn2ab_pkg::MAX_SUBSAMPLES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [2:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [7:0]  data_byte,
  input  logic [15:0] clear_bytes,
  input  logic [31:0] encrypted_bytes,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [7:0]  out_byte,
  output logic [15:0] clear_count,
  output logic [1:0]  status,
  output logic        last_res
);

  lpn2ab_pkg::cmd_t   f_cmd, q_cmd;
  lpn2ab_pkg::ps_wr_t ps_wr;
  logic f_push, q_full, q_valid, q_pop, b_busy;

  // classification
  lpn2ab_front #(
    .PARAM_SET_DEPTH(PARAM_SET_DEPTH),
    .MAX_SUBSAMPLES (MAX_SUBSAMPLES)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .data_byte      (data_byte),
    .clear_bytes    (clear_bytes),
    .encrypted_bytes(encrypted_bytes),
    .last           (last),
    .cmd            (f_cmd),
    .cmd_push       (f_push),
    .cmd_full       (q_full),
    .back_idle      (!q_valid && !b_busy),
    .ps_wr          (ps_wr)
  );

  // command queue
  lpn2ab_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .wdata (f_cmd),
    .full  (q_full),
    .pop   (q_pop),
    .rvalid(q_valid),
    .rdata (q_cmd)
  );

  // beat generation
  lpn2ab_back #(
    .PARAM_SET_DEPTH(PARAM_SET_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .ps_wr      (ps_wr),
    .cmd_valid  (q_valid),
    .cmd        (q_cmd),
    .cmd_pop    (q_pop),
    .busy       (b_busy),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .out_byte   (out_byte),
    .clear_count(clear_count),
    .status     (status),
    .last_res   (last_res)
  );

endmodule
